@@ rtl/stq_pkg.sv @@
// Shared types, command codes and sizes of the sorted timeout queue.
`default_nettype none
package stq_pkg;

  localparam int STQ_DEPTH   = 16;
  localparam int MAX_RESULTS = 16;

  localparam int FUNC_W  = 3;
  localparam int TABLE_W = 8;
  localparam int KEY_W   = 32;
  localparam int TOUT_W  = 16;
  localparam int TIME_W  = 32;
  localparam int OCC_W   = 5;

  localparam logic [FUNC_W-1:0] FUNC_ADD       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL_KEY   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL_TABLE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd4;

  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  // Command broadcast to every cell of the chain.
  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_POP  = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0]  expiry;
    logic [TABLE_W-1:0] table_id;
    logic [KEY_W-1:0]   key_id;
  } stq_entry_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [TIME_W-1:0]  now;
    logic [TOUT_W-1:0]  timeout;
    logic [TABLE_W-1:0] table_id;
    logic [KEY_W-1:0]   key_id;
    logic               by_key;
  } stq_ctrl_t;

  // Per-cell flags that ripple to the right neighbor or go back to control.
  typedef struct packed {
    logic take;     // new entry goes here or further left
    logic remove;   // a delete hit lies here or further left
    logic expired;  // valid entry due at or before the current time
  } stq_stat_t;

endpackage
`default_nettype wire

@@ rtl/sorted_timeout_queue_top.sv @@
// Top level of the sorted timeout queue: control sequencer around a chain of cells.
`default_nettype none
// Channel   Direction  Handshake            Payload
// in_       request    in_valid / in_stall  func, table_id, key_id, timeout
// out_      result     out_valid / out_stall kind, table, key, occupancy, last
//
// Steps: an add is accepted, then the chain shifts once. A delete squeezes
// out one matching entry per cycle until none is left. A tick pops expired
// entries off the front, one per cycle while the output is not stalled, up to
// MAX_RESULTS; the single output register sets that pace. Clear empties the count.
// Reset (synchronous, active low) empties the queue and zeroes the clock;
// cell contents are not cleared. A stalled output holds the drain in place.
module sorted_timeout_queue_top #(
  parameter int DEPTH = stq_pkg::STQ_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [stq_pkg::FUNC_W-1:0]   in_func,
  input  wire  [stq_pkg::TABLE_W-1:0]  in_table_id,
  input  wire  [stq_pkg::KEY_W-1:0]    in_key_id,
  input  wire  [stq_pkg::TOUT_W-1:0]   in_timeout,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_kind,
  output logic [stq_pkg::TABLE_W-1:0]  out_table,
  output logic [stq_pkg::KEY_W-1:0]    out_key,
  output logic [stq_pkg::OCC_W-1:0]    out_occupancy,
  output logic                         out_last
);
  import stq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ADD   = 2'd1;
  localparam logic [1:0] ST_DEL   = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // Control state.
  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [NW-1:0]      popped_r, popped_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Held request fields.
  logic [TABLE_W-1:0] op_table_r, op_table_nxt;
  logic [KEY_W-1:0]   op_key_r, op_key_nxt;
  logic [TOUT_W-1:0]  op_tout_r, op_tout_nxt;
  logic               op_by_key_r, op_by_key_nxt;

  // Result register.
  logic               out_kind_r, out_kind_nxt;
  logic [TABLE_W-1:0] out_table_r, out_table_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [CW-1:0]      out_count_r, out_count_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic               slot_free;
  logic               full;
  logic [1:0]         cmd;
  logic [CW+OCC_W-1:0] occ_ext;

  stq_ctrl_t          ctrl;
  stq_entry_t         cell_entry [DEPTH];
  stq_stat_t          cell_stat  [DEPTH];

  assign full      = (count_r == CW'(DEPTH));
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign ctrl.cmd      = cmd;
  assign ctrl.now      = time_r;
  assign ctrl.timeout  = op_tout_r;
  assign ctrl.table_id = op_table_r;
  assign ctrl.key_id   = op_key_r;
  assign ctrl.by_key   = op_by_key_r;

  // Chain of cells: slot 0 holds the nearest expiry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    stq_stat_t  stat_left;
    stq_entry_t entry_left;
    stq_entry_t entry_right;
    logic       valid;

    assign valid = (count_r > CW'(i));

    if (i == 0) begin : g_head
      assign stat_left  = '0;
      assign entry_left = cell_entry[0];
    end else begin : g_body
      assign stat_left  = cell_stat[i-1];
      assign entry_left = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign entry_right = cell_entry[i];
    end else begin : g_inner
      assign entry_right = cell_entry[i+1];
    end

    stq_cell u_cell (
      .clk         (clk),
      .valid       (valid),
      .ctrl        (ctrl),
      .stat_left   (stat_left),
      .entry_left  (entry_left),
      .entry_right (entry_right),
      .entry       (cell_entry[i]),
      .stat        (cell_stat[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    time_nxt      = time_r;
    popped_nxt    = popped_r;
    op_table_nxt  = op_table_r;
    op_key_nxt    = op_key_r;
    op_tout_nxt   = op_tout_r;
    op_by_key_nxt = op_by_key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_table_nxt = out_table_r;
    out_key_nxt   = out_key_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;
    cmd           = CMD_HOLD;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_table_nxt  = in_table_id;
          op_key_nxt    = in_key_id;
          op_tout_nxt   = in_timeout;
          op_by_key_nxt = (in_func == FUNC_DEL_KEY);
          case (in_func)
            FUNC_ADD: begin
              if (full) begin
                // Reject: the output slot is free here, since stalls block accept.
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_REJECT;
                out_table_nxt = in_table_id;
                out_key_nxt   = in_key_id;
                out_count_nxt = count_r;
                out_last_nxt  = 1'b1;
              end else begin
                state_nxt = ST_ADD;
              end
            end
            FUNC_DEL_KEY, FUNC_DEL_TABLE: begin
              state_nxt = ST_DEL;
            end
            FUNC_TICK: begin
              time_nxt   = time_r + 1'b1;
              popped_nxt = '0;
              state_nxt  = ST_DRAIN;
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADD: begin
        cmd       = CMD_ADD;
        count_nxt = count_r + 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DEL: begin
        // Drop the first match each cycle until none is left.
        if (cell_stat[DEPTH-1].remove) begin
          cmd       = CMD_DEL;
          count_nxt = count_r - 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!cell_stat[0].expired) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          // Pop the front entry into the result register.
          cmd           = CMD_POP;
          count_nxt     = count_r - 1'b1;
          popped_nxt    = popped_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EXPIRED;
          out_table_nxt = cell_entry[0].table_id;
          out_key_nxt   = cell_entry[0].key_id;
          out_count_nxt = count_r - 1'b1;
          out_last_nxt  = !(cell_stat[1].expired && (popped_r + 1'b1 < NW'(MAX_RESULTS)));
          if (out_last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      time_r      <= '0;
      popped_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      popped_r    <= popped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_table_r  <= op_table_nxt;
    op_key_r    <= op_key_nxt;
    op_tout_r   <= op_tout_nxt;
    op_by_key_r <= op_by_key_nxt;
    out_kind_r  <= out_kind_nxt;
    out_table_r <= out_table_nxt;
    out_key_r   <= out_key_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Occupancy reports the low bits of the count, whatever the depth.
  assign occ_ext       = {{OCC_W{1'b0}}, out_count_r};
  assign out_occupancy = occ_ext[OCC_W-1:0];
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_table     = out_table_r;
  assign out_key       = out_key_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

@@ rtl/stq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module stq_cell (
  input  wire                      clk,
  input  wire                      valid,
  input  wire stq_pkg::stq_ctrl_t  ctrl,
  input  wire stq_pkg::stq_stat_t  stat_left,
  input  wire stq_pkg::stq_entry_t entry_left,
  input  wire stq_pkg::stq_entry_t entry_right,
  output stq_pkg::stq_entry_t      entry,
  output stq_pkg::stq_stat_t       stat
);
  import stq_pkg::*;

  stq_entry_t        entry_r;
  stq_entry_t        entry_nxt;
  stq_entry_t        new_entry;
  logic [TIME_W-1:0] time_left;
  logic              later;
  logic              hit;

  assign time_left = entry_r.expiry - ctrl.now;
  assign later = valid && ($signed(time_left) > $signed({{(TIME_W-TOUT_W){1'b0}}, ctrl.timeout}));
  assign hit   = valid && (entry_r.table_id == ctrl.table_id)
                 && (!ctrl.by_key || (entry_r.key_id == ctrl.key_id));

  assign stat.take    = later || !valid;
  assign stat.remove  = hit || stat_left.remove;
  assign stat.expired = valid && ($signed(time_left) <= $signed({TIME_W{1'b0}}));

  assign new_entry.expiry   = ctrl.now + {{(TIME_W-TOUT_W){1'b0}}, ctrl.timeout};
  assign new_entry.table_id = ctrl.table_id;
  assign new_entry.key_id   = ctrl.key_id;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.cmd)
      CMD_ADD: begin
        // Insert at the first later slot; push the tail one to the right.
        if (stat.take) begin
          entry_nxt = stat_left.take ? entry_left : new_entry;
        end
      end
      CMD_DEL: begin
        if (stat.remove) begin
          entry_nxt = entry_right;
        end
      end
      CMD_POP: begin
        entry_nxt = entry_right;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire
